/* rtl/pst_pkg.sv */
// shared types and constants of the palindromic tree append core
`timescale 1ns / 1ps
`default_nettype none
package pst_pkg;
  localparam int MAX_LEN    = 4096;
  localparam int ALPHABET   = 26;
  localparam int NODE_DEPTH = MAX_LEN + 3;
  localparam int NODE_W     = 13;
  localparam int TEXT_W     = 13;
  localparam int EDGE_DEPTH = NODE_DEPTH * ALPHABET;
  localparam int EDGE_AW    = $clog2(EDGE_DEPTH);
  localparam int SUM_W      = 30;
  localparam logic [SUM_W-1:0] MOD_RESET = 30'd1000000007;

  typedef struct packed {
    logic [4:0] symbol;
    logic       restart;
  } pst_in_t;

  typedef struct packed {
    logic [12:0]      suffix_count;
    logic [SUM_W-1:0] suffix_length_sum;
    logic             created_node;
    logic             overflow;
  } pst_out_t;
endpackage
`default_nettype wire

/* rtl/pst_mod_unit.sv */
// bit-serial remainder unit for the chain length sums
`timescale 1ns / 1ps
`default_nettype none
module pst_mod_unit (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [pst_pkg::SUM_W:0]   x_i,
  input  wire logic [pst_pkg::SUM_W-1:0] m_i,
  output logic                           done_o,
  output logic [pst_pkg::SUM_W-1:0]      r_o
);
  import pst_pkg::*;

  logic              busy_q, busy_d, done_q, done_d;
  logic [SUM_W:0]    x_q, x_d, r_q, r_d;
  logic [SUM_W-1:0]  m_q, m_d;
  logic [4:0]        cnt_q, cnt_d;
  logic [SUM_W:0]    shifted;

  // one quotient bit per cycle: shift in, compare, subtract
  always_comb begin
    busy_d  = busy_q;
    done_d  = 1'b0;
    x_d     = x_q;
    r_d     = r_q;
    m_d     = m_q;
    cnt_d   = cnt_q;
    shifted = {r_q[SUM_W-1:0], x_q[SUM_W]};
    if (start_i) begin
      x_d   = x_i;
      m_d   = m_i;
      r_d   = '0;
      cnt_d = 5'(SUM_W);
      if (m_i == '0) begin
        r_d    = {1'b0, x_i[SUM_W-1:0]};
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
      end
    end else if (busy_q) begin
      x_d = {x_q[SUM_W-1:0], 1'b0};
      r_d = (shifted >= {1'b0, m_q}) ? shifted - {1'b0, m_q} : shifted;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    r_q <= r_d;
    m_q <= m_d;
  end

  assign done_o = done_q;
  assign r_o    = r_q[SUM_W-1:0];
endmodule
`default_nettype wire

/* rtl/palindromic_suffix_tree_append_core.sv */
// top level of the palindromic tree append core
// usage:
//   in channel (valid/ready) carries one beat per symbol plus a restart flag;
//   restart empties the tree and the text before the symbol goes in
//   out channel (valid/ready) returns one beat per input beat, in order
//   cfg_we_i/cfg_wdata_i write the modulus; write it only idle
// operation and throughput:
//   the core takes one symbol at a time; in_ready_o is high only while idle
//   a symbol that reuses a node walks the suffix links, testing each node on
//   the walk, then looks up the edge and checks the child
//   a new node above length one adds a second walk and an edge lookup; every
//   new node goes through the serial remainder unit (no division, modulus zero)
// reset:
//   text empty, two roots, modulus 1000000007; no memory clearing pass:
//   stale edge entries are rejected by checking the child's parent and symbol
// stall:
//   a finished result sits in the output register; the core goes idle
//   again once it has loaded the result, and a second result waits until
//   the first beat is taken
`timescale 1ns / 1ps
`default_nettype none
module palindromic_suffix_tree_append_core (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      in_valid_i,
  output logic                           in_ready_o,
  input  wire pst_pkg::pst_in_t          in_data_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output pst_pkg::pst_out_t              out_data_o,
  input  wire logic                      cfg_we_i,
  input  wire logic [pst_pkg::SUM_W-1:0] cfg_wdata_i
);
  import pst_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_WLEN  = 9'b000000010,
    S_WTXT  = 9'b000000100,
    S_WCHK  = 9'b000001000,
    S_FOUND = 9'b000010000,
    S_EDAT  = 9'b000100000,
    S_NCHK  = 9'b001000000,
    S_MOD   = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_e;

  typedef struct packed {
    logic [12:0]       len;
    logic [NODE_W-1:0] link;
    logic [12:0]       count;
    logic [SUM_W-1:0]  sum;
    logic [NODE_W-1:0] parent;
    logic [4:0]        sym;
  } node_t;

  state_e state_q, state_d;

  // memories
  logic [4:0]        text_mem [MAX_LEN+1];
  node_t             node_mem [NODE_DEPTH];
  // edge entries start out as no edge; stale ones fail the parent check
  bit   [NODE_W-1:0] edge_mem [EDGE_DEPTH];

  logic              text_we;
  logic [TEXT_W-1:0] text_waddr, text_raddr;
  logic [4:0]        text_rdata_q;
  logic              node_we;
  logic [NODE_W-1:0] node_waddr, node_raddr, node_raddr_q;
  node_t             node_wdata, node_rdata_q, nd;
  logic              edge_we;
  logic [EDGE_AW-1:0] edge_waddr, edge_raddr;
  logic [NODE_W-1:0] edge_wdata, edge_rdata_q;

  always_ff @(posedge clk_i) begin
    if (text_we) text_mem[text_waddr] <= 5'(in_data_i.symbol);
    text_rdata_q <= text_mem[text_raddr];
    if (node_we) node_mem[node_waddr] <= node_wdata;
    node_rdata_q <= node_mem[node_raddr];
    node_raddr_q <= node_raddr;
    if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
    edge_rdata_q <= edge_mem[edge_raddr];
  end

  // the empty root reads as length 0 linked to the imaginary root
  always_comb begin
    nd = node_rdata_q;
    if (node_raddr_q == NODE_W'(2)) begin
      nd      = '0;
      nd.link = NODE_W'(1);
    end
  end

  // control and working registers
  logic [TEXT_W-1:0] tl_q, tl_d;
  logic [NODE_W-1:0] nt_q, nt_d, last_q, last_d;
  logic [NODE_W-1:0] v_q, v_d, cur_q, cur_d, curlink_q, curlink_d, c_q, c_d;
  logic [NODE_W-1:0] link_q, link_d;
  logic [12:0]       len_q, len_d, curlen_q, curlen_d, nnlen_q, nnlen_d;
  logic [12:0]       lcnt_q, lcnt_d;
  logic              curneg_q, curneg_d, fneg_q, fneg_d, phase_q, phase_d;
  logic [4:0]        sym_q, sym_d;
  logic [SUM_W-1:0]  mod_q, mod_d;
  logic              out_valid_q, out_valid_d;
  pst_out_t          out_q, out_d, res_q, res_d;

  logic              mod_start, mod_done;
  logic [SUM_W:0]    mod_x;
  logic [SUM_W-1:0]  mod_r;
  logic [SUM_W-1:0]  lsum_q, lsum_d;
  logic [13:0]       len_p2;
  logic              child_ok;
  logic [TEXT_W-1:0] tl_eff;
  logic [NODE_W-1:0] last_eff;

  pst_mod_unit u_mod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mod_start),
    .x_i     (mod_x),
    .m_i     (mod_q),
    .done_o  (mod_done),
    .r_o     (mod_r)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign len_p2     = {1'b0, nd.len} + 14'd2;
  // a stored edge counts only if its child was built from this parent and symbol
  assign child_ok   = (c_q >= NODE_W'(3)) && (c_q <= nt_q) &&
                      (node_rdata_q.parent == v_q) && (node_rdata_q.sym == sym_q);
  assign mod_x      = {1'b0, lsum_q} + (SUM_W+1)'(nnlen_q);

  always_comb begin
    state_d     = state_q;
    tl_d        = tl_q;
    nt_d        = nt_q;
    last_d      = last_q;
    v_d         = v_q;
    cur_d       = cur_q;
    curlink_d   = curlink_q;
    curlen_d    = curlen_q;
    curneg_d    = curneg_q;
    c_d         = c_q;
    link_d      = link_q;
    len_d       = len_q;
    nnlen_d     = nnlen_q;
    lcnt_d      = lcnt_q;
    lsum_d      = lsum_q;
    fneg_d      = fneg_q;
    phase_d     = phase_q;
    sym_d       = sym_q;
    mod_d       = cfg_we_i ? cfg_wdata_i : mod_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    text_we     = 1'b0;
    text_waddr  = tl_q;
    text_raddr  = tl_q;
    node_we     = 1'b0;
    node_waddr  = nt_q;
    node_wdata  = '0;
    node_raddr  = v_q;
    edge_we     = 1'b0;
    edge_waddr  = EDGE_AW'(cur_q * ALPHABET + 32'(sym_q));
    edge_wdata  = nt_q + NODE_W'(1);
    edge_raddr  = EDGE_AW'(v_q * ALPHABET + 32'(sym_q));
    mod_start   = 1'b0;
    tl_eff      = in_data_i.restart ? '0 : tl_q;
    last_eff    = in_data_i.restart ? NODE_W'(2) : last_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_data_i.restart) begin
            tl_d   = '0;
            nt_d   = NODE_W'(2);
            last_d = NODE_W'(2);
          end
          res_d = '0;
          sym_d = in_data_i.symbol;
          if (32'(in_data_i.symbol) >= ALPHABET) begin
            state_d = S_DONE;
          end else if (32'(tl_eff) >= MAX_LEN) begin
            res_d.overflow = 1'b1;
            state_d        = S_DONE;
          end else begin
            tl_d       = tl_eff + TEXT_W'(1);
            text_we    = 1'b1;
            text_waddr = tl_eff + TEXT_W'(1);
            v_d        = last_eff;
            phase_d    = 1'b0;
            state_d    = S_WLEN;
          end
        end
      end
      // start one hop: nodes 0 and 1 (the imaginary root) and out-of-range nodes end at the imaginary root
      S_WLEN: begin
        if (v_q <= NODE_W'(1) || v_q > nt_q) begin
          v_d     = NODE_W'(1);
          fneg_d  = 1'b1;
          state_d = S_FOUND;
        end else begin
          node_raddr = v_q;
          state_d    = S_WTXT;
        end
      end
      S_WTXT: begin
        len_d  = nd.len;
        link_d = nd.link;
        if ({1'b0, tl_q} >= len_p2) begin
          text_raddr = TEXT_W'({1'b0, tl_q} - len_p2 + 14'd1);
          state_d    = S_WCHK;
        end else begin
          v_d     = nd.link;
          state_d = S_WLEN;
        end
      end
      S_WCHK: begin
        if (text_rdata_q == sym_q) begin
          fneg_d  = 1'b0;
          state_d = S_FOUND;
        end else begin
          v_d     = link_q;
          state_d = S_WLEN;
        end
      end
      S_FOUND: begin
        if (!phase_q) begin
          cur_d     = v_q;
          curneg_d  = fneg_q;
          curlen_d  = len_q;
          curlink_d = link_q;
        end
        edge_raddr = EDGE_AW'(v_q * ALPHABET + 32'(sym_q));
        state_d    = S_EDAT;
      end
      S_EDAT: begin
        c_d        = edge_rdata_q;
        node_raddr = edge_rdata_q;
        state_d    = S_NCHK;
      end
      S_NCHK: begin
        if (!phase_q) begin
          if (child_ok) begin
            last_d                  = c_q;
            res_d.suffix_count      = node_rdata_q.count;
            res_d.suffix_length_sum = node_rdata_q.sum;
            state_d                 = S_DONE;
          end else begin
            edge_we    = 1'b1;
            edge_waddr = EDGE_AW'(cur_q * ALPHABET + 32'(sym_q));
            nnlen_d    = curneg_q ? 13'd1 : curlen_q + 13'd2;
            if (curneg_q) begin
              link_d    = NODE_W'(2);
              lcnt_d    = '0;
              lsum_d    = '0;
              mod_start = 1'b0;
              phase_d   = 1'b1;
              state_d   = S_MOD;
            end else begin
              phase_d = 1'b1;
              v_d     = curlink_q;
              state_d = S_WLEN;
            end
          end
        end else begin
          link_d  = child_ok ? c_q : NODE_W'(2);
          lcnt_d  = child_ok ? node_rdata_q.count : '0;
          lsum_d  = child_ok ? node_rdata_q.sum : '0;
          state_d = S_MOD;
        end
        if (state_d == S_MOD) begin
          // kick the remainder unit in the next cycle, once the sum is registered
          c_d = '0;
        end
      end
      S_MOD: begin
        // c_q doubles as a started flag for the remainder unit
        if (c_q == '0) begin
          mod_start = 1'b1;
          c_d       = NODE_W'(1);
        end else if (mod_done) begin
          node_we           = 1'b1;
          node_waddr        = nt_q + NODE_W'(1);
          node_wdata.len    = nnlen_q;
          node_wdata.link   = link_q;
          node_wdata.count  = lcnt_q + 13'd1;
          node_wdata.sum    = mod_r;
          node_wdata.parent = cur_q;
          node_wdata.sym    = sym_q;
          nt_d              = nt_q + NODE_W'(1);
          last_d            = nt_q + NODE_W'(1);
          res_d.suffix_count      = lcnt_q + 13'd1;
          res_d.suffix_length_sum = mod_r;
          res_d.created_node      = 1'b1;
          state_d                 = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tl_q        <= '0;
      nt_q        <= NODE_W'(2);
      last_q      <= NODE_W'(2);
      mod_q       <= MOD_RESET;
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
      c_q         <= '0;
    end else begin
      state_q     <= state_d;
      tl_q        <= tl_d;
      nt_q        <= nt_d;
      last_q      <= last_d;
      mod_q       <= mod_d;
      out_valid_q <= out_valid_d;
      phase_q     <= phase_d;
      c_q         <= c_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q       <= v_d;
    cur_q     <= cur_d;
    curlink_q <= curlink_d;
    curlen_q  <= curlen_d;
    curneg_q  <= curneg_d;
    link_q    <= link_d;
    len_q     <= len_d;
    nnlen_q   <= nnlen_d;
    lcnt_q    <= lcnt_d;
    lsum_q    <= lsum_d;
    fneg_q    <= fneg_d;
    sym_q     <= sym_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // remainder results only show up while a new node is being finished
  a_mod_done_in_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mod_done |-> state_q == S_MOD)
    else $error("remainder unit finished outside node creation");
  a_nodes_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nt_q <= NODE_W'(NODE_DEPTH - 1) && nt_q <= NODE_W'(2) + NODE_W'(tl_q))
    else $error("node count exceeds text length bound");
  a_last_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q >= NODE_W'(2) && last_q <= nt_q)
    else $error("last node outside the live node range");
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && (!out_valid_q || out_ready_i)) |=> out_valid_q)
    else $error("finished result was not presented");
endmodule
`default_nettype wire
